[src/affra_pkg.sv]
// Package with the shared constants, status codes, register index and request types of the region allocator.
`default_nettype none
package affra_pkg;
    localparam int TableEntries = 16;
    localparam int IdxW = $clog2(TableEntries);
    localparam logic [23:0] MinAlign = 24'd16;
    localparam logic [23:0] MaxAlign = 24'd65536;
    localparam logic [24:0] RegionFloor = 25'h100000;
    localparam logic [24:0] RegionCeil = 25'h1000000;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_INPUT = 3'd1,
        ST_INACTIVE = 3'd2,
        ST_UNCONFIGURED = 3'd3,
        ST_UNKNOWN_ID = 3'd4,
        ST_NO_CAPACITY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE = 2'd0,
        REG_SIZE = 2'd1,
        REG_ACTIVE = 2'd2
    } reg_idx_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic        is_release;
        logic        pass;
        status_t     early_status;
        logic [23:0] bytes;
        logic [23:0] align;
        logic [31:0] rid;
    } job_t;
endpackage
`default_nettype wire

[src/affra_front.sv]
// Front part: checks operands, session and region and classifies each request.
`default_nettype none
module affra_front
    import affra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [23:0] request_bytes,
    input  wire logic [23:0] alignment,
    input  wire logic [31:0] release_id,
    input  wire logic        session_active,
    input  wire logic [23:0] region_base,
    input  wire logic [23:0] region_size,
    output logic             job_valid,
    input  wire logic        job_stall,
    output job_t             job
);
    logic  ok_in;
    logic  reg_ok;
    job_t  job_reg;
    logic  valid_reg;
    logic [24:0] lim;

    always_comb
    begin
        lim = {1'b0, region_base} + {1'b0, region_size};
        reg_ok = ({1'b0, region_base} >= RegionFloor) && (region_size != 24'd0)
            && (region_base[15:0] == 16'd0) && (region_size[15:0] == 16'd0)
            && (lim <= RegionCeil);
        if (kind == 1'b0)
        begin
            ok_in = (request_bytes != 24'd0) && (alignment >= MinAlign)
                && (alignment <= MaxAlign)
                && ((alignment & (alignment - 24'd1)) == 24'd0)
                && (release_id == 32'd0);
        end
        else
        begin
            ok_in = (request_bytes == 24'd0) && (alignment == 24'd0)
                && (release_id != 32'd0);
        end
    end

    assign in_stall = valid_reg && job_stall;
    assign job_valid = valid_reg;
    assign job = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            job_reg.is_release <= kind;
            job_reg.bytes <= request_bytes;
            job_reg.align <= alignment;
            job_reg.rid <= release_id;
            job_reg.pass <= ok_in && session_active && reg_ok;
            if (!ok_in)
            begin
                job_reg.early_status <= ST_BAD_INPUT;
            end
            else if (!session_active)
            begin
                job_reg.early_status <= ST_INACTIVE;
            end
            else
            begin
                job_reg.early_status <= ST_UNCONFIGURED;
            end
        end
    end
endmodule
`default_nettype wire

[src/affra_back.sv]
// Back part: table of reservations, first-fit search sequencer and release.
`default_nettype none
module affra_back
    import affra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic [23:0] region_base,
    input  wire logic [23:0] region_size,
    input  wire logic        job_valid,
    output logic             job_stall,
    input  job_t             job,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      assigned_id,
    output logic [23:0]      granted_address
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    logic [31:0] id_reg [TableEntries];
    logic [23:0] start_reg [TableEntries];
    logic [23:0] len_reg [TableEntries];
    logic [31:0] ident_reg;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW:0] pass_reg;
    logic [24:0] cand_reg;
    job_t job_r;
    logic [2:0]  st_reg;
    logic [31:0] oid_reg;
    logic [23:0] oaddr_reg;
    logic oval_reg;
    logic have_free;
    logic [IdxW-1:0] free_idx;
    logic rel_hit;
    logic [IdxW-1:0] rel_idx;
    logic [24:0] lim;
    logic [24:0] amask;
    logic [25:0] cend;
    logic [24:0] eend;
    logic hit;
    logic [31:0] nid;

    always_comb
    begin
        have_free = 1'b0;
        free_idx = '0;
        rel_hit = 1'b0;
        rel_idx = '0;
        for (int i = TableEntries - 1; i >= 0; i--)
        begin
            if (id_reg[i] == 32'd0)
            begin
                have_free = 1'b1;
                free_idx = IdxW'(i);
            end
            if (id_reg[i] == job_r.rid)
            begin
                rel_hit = 1'b1;
                rel_idx = IdxW'(i);
            end
        end
        lim = {1'b0, region_base} + {1'b0, region_size};
        amask = {1'b0, job_r.align} - 25'd1;
        cend = {1'b0, cand_reg} + {2'b0, job_r.bytes};
        eend = {1'b0, start_reg[idx_reg]} + {1'b0, len_reg[idx_reg]};
        hit = (id_reg[idx_reg] != 32'd0) && (cand_reg < eend)
            && ({2'b0, start_reg[idx_reg]} < cend);
        nid = (ident_reg == 32'd0) ? 32'd1 : ident_reg;
    end

    assign job_stall = (state_reg != S_IDLE) || oval_reg;
    assign out_valid = oval_reg;
    assign status = st_reg;
    assign assigned_id = oid_reg;
    assign granted_address = oaddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg <= 1'b0;
            ident_reg <= 32'd1;
            for (int i = 0; i < TableEntries; i++)
            begin
                id_reg[i] <= 32'd0;
                start_reg[i] <= 24'd0;
                len_reg[i] <= 24'd0;
            end
        end
        else
        begin
            if (oval_reg && !out_stall)
            begin
                oval_reg <= 1'b0;
            end
            if (clear)
            begin
                ident_reg <= 32'd1;
                for (int i = 0; i < TableEntries; i++)
                begin
                    id_reg[i] <= 32'd0;
                    start_reg[i] <= 24'd0;
                    len_reg[i] <= 24'd0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !oval_reg)
                    begin
                        job_r <= job;
                        idx_reg <= '0;
                        pass_reg <= '0;
                        cand_reg <= ({1'b0, region_base} + {1'b0, job.align} - 25'd1)
                            & ~({1'b0, job.align} - 25'd1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!job_r.pass)
                    begin
                        st_reg <= job_r.early_status;
                        oid_reg <= 32'd0;
                        oaddr_reg <= 24'd0;
                        state_reg <= S_DONE;
                    end
                    else if (job_r.is_release)
                    begin
                        oid_reg <= 32'd0;
                        oaddr_reg <= 24'd0;
                        if (rel_hit)
                        begin
                            id_reg[rel_idx] <= 32'd0;
                            start_reg[rel_idx] <= 24'd0;
                            len_reg[rel_idx] <= 24'd0;
                            st_reg <= ST_OK;
                        end
                        else
                        begin
                            st_reg <= ST_UNKNOWN_ID;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (!have_free || cend > {1'b0, lim})
                    begin
                        st_reg <= ST_NO_CAPACITY;
                        oid_reg <= 32'd0;
                        oaddr_reg <= 24'd0;
                        state_reg <= S_DONE;
                    end
                    else if (hit)
                    begin
                        cand_reg <= (eend + amask) & ~amask;
                        idx_reg <= '0;
                        pass_reg <= pass_reg + 1'b1;
                        if (pass_reg == (IdxW + 1)'(TableEntries))
                        begin
                            st_reg <= ST_NO_CAPACITY;
                            oid_reg <= 32'd0;
                            oaddr_reg <= 24'd0;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (idx_reg != IdxW'(TableEntries - 1))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        id_reg[free_idx] <= nid;
                        start_reg[free_idx] <= cand_reg[23:0];
                        len_reg[free_idx] <= job_r.bytes;
                        ident_reg <= nid + 32'd1;
                        st_reg <= ST_OK;
                        oid_reg <= nid;
                        oaddr_reg <= cand_reg[23:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!oval_reg || !out_stall)
                    begin
                        oval_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[src/aligned_first_fit_region_allocator_unit.sv]
// Top level of the aligned first-fit region allocator with its register port.
`default_nettype none
// Each request is classified by the front part and queued in a single-beat register; the
// back part then runs first-fit one table entry per cycle. A release or a rejected request
// is settled without the sequential scan, while an allocate restarts its scan of the
// sixteen-entry table from the first entry after each move of the candidate. The back part
// takes a new request only once the previous result beat has been accepted, so a stalled
// output holds up the input.
// Configuration must only be written while no request is in flight.
module aligned_first_fit_region_allocator_unit
    import affra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [23:0] request_bytes,
    input  wire logic [23:0] alignment,
    input  wire logic [31:0] release_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      assigned_id,
    output logic [23:0]      granted_address
);
    logic [23:0] base_reg;
    logic [23:0] size_reg;
    logic        active_reg;
    logic        wr;
    logic        clear;
    logic        job_valid;
    logic        job_stall;
    job_t        job;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign widx = reg_idx_t'(paddr[3:2]);
    assign clear = wr && (((widx == REG_BASE || widx == REG_SIZE) && !active_reg)
        || (widx == REG_ACTIVE && !pwdata[0]));

    always_comb
    begin
        unique case (widx)
            REG_BASE:   prdata = {8'd0, base_reg};
            REG_SIZE:   prdata = {8'd0, size_reg};
            REG_ACTIVE: prdata = {31'd0, active_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 24'd0;
            size_reg <= 24'd0;
            active_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (widx)
                REG_BASE:
                begin
                    if (!active_reg)
                    begin
                        base_reg <= pwdata[23:0];
                    end
                end
                REG_SIZE:
                begin
                    if (!active_reg)
                    begin
                        size_reg <= pwdata[23:0];
                    end
                end
                REG_ACTIVE:
                begin
                    active_reg <= pwdata[0];
                    if (!pwdata[0])
                    begin
                        base_reg <= 24'd0;
                        size_reg <= 24'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    affra_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .request_bytes(request_bytes), .alignment(alignment), .release_id(release_id),
        .session_active(active_reg), .region_base(base_reg), .region_size(size_reg),
        .job_valid(job_valid), .job_stall(job_stall), .job(job)
    );

    affra_back u_back (
        .clk(clk), .rst_n(rst_n), .clear(clear), .region_base(base_reg),
        .region_size(size_reg), .job_valid(job_valid), .job_stall(job_stall), .job(job),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .assigned_id(assigned_id), .granted_address(granted_address)
    );
endmodule
`default_nettype wire

[src/affra_checker.sv]
// Port-level checker for the region allocator and its bind statement.
`default_nettype none
module affra_checker
    import affra_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [31:0] assigned_id,
    input wire logic [23:0] granted_address,
    input wire logic        pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)) else $error("beat lost");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> assigned_id == 32'd0 && granted_address == 24'd0)
        else $error("failed result carries data");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NO_CAPACITY) else $error("bad status");
    a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule
bind aligned_first_fit_region_allocator_unit affra_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .assigned_id(assigned_id), .granted_address(granted_address),
    .pready(pready)
);
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the aligned first-fit region allocator.
`timescale 1ns / 1ps
module testbench;
    import affra_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [23:0] request_bytes = '0;
    logic [23:0] alignment = '0;
    logic [31:0] release_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic [23:0] granted_address;

    typedef struct packed {
        status_t     st;
        logic [31:0] id;
        logic [23:0] addr;
    } grant_t;

    grant_t      pending_grants[$];
    logic [23:0] mdl_base;
    logic [23:0] mdl_size;
    logic        mdl_active;
    logic [31:0] tbl_id[TableEntries];
    logic [23:0] tbl_start[TableEntries];
    logic [23:0] tbl_len[TableEntries];
    logic [31:0] mdl_next_id;
    logic [31:0] live_ids[$];

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned grants_ok = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;

    aligned_first_fit_region_allocator_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void wipe_table();
        for (int i = 0; i < TableEntries; i++)
        begin
            tbl_id[i] = '0;
            tbl_start[i] = '0;
            tbl_len[i] = '0;
        end
        mdl_next_id = 32'd1;
        live_ids.delete();
    endfunction

    function automatic void model_write(reg_idx_t idx, logic [31:0] value);
        if (idx == REG_BASE || idx == REG_SIZE)
        begin
            if (!mdl_active)
            begin
                wipe_table();
                if (idx == REG_BASE)
                    mdl_base = value[23:0];
                else
                    mdl_size = value[23:0];
            end
        end
        else if (idx == REG_ACTIVE)
        begin
            mdl_active = value[0];
            if (!mdl_active)
            begin
                wipe_table();
                mdl_base = '0;
                mdl_size = '0;
            end
        end
    endfunction

    function automatic logic [24:0] round_up(logic [24:0] v, logic [24:0] a);
        return (v + a - 25'd1) & ~(a - 25'd1);
    endfunction

    function automatic grant_t predict_grant(logic k, logic [23:0] b, logic [23:0] a,
                                             logic [31:0] rid);
        grant_t      g;
        logic        ok;
        logic        region_valid;
        logic [25:0] lim;
        logic [25:0] cand;
        logic [25:0] e;
        int          slot;
        logic        moved;
        g = '{st: ST_OK, id: '0, addr: '0};
        if (k == 1'b0)
            ok = b != 0 && a >= MinAlign && a <= MaxAlign && (a & (a - 1)) == 0 && rid == 0;
        else
            ok = b == 0 && a == 0 && rid != 0;
        region_valid = mdl_base >= 24'h100000 && mdl_size != 0 && mdl_base[15:0] == 0 &&
                       mdl_size[15:0] == 0 && ({2'b0, mdl_base} + mdl_size) <= 26'h1000000;
        if (!ok)
            g.st = ST_BAD_INPUT;
        else if (!mdl_active)
            g.st = ST_INACTIVE;
        else if (!region_valid)
            g.st = ST_UNCONFIGURED;
        else if (k == 1'b1)
        begin
            g.st = ST_UNKNOWN_ID;
            for (int i = 0; i < TableEntries; i++)
            begin
                if (g.st == ST_UNKNOWN_ID && tbl_id[i] == rid)
                begin
                    tbl_id[i] = '0;
                    tbl_start[i] = '0;
                    tbl_len[i] = '0;
                    g.st = ST_OK;
                end
            end
        end
        else
        begin
            g.st = ST_NO_CAPACITY;
            lim = {2'b0, mdl_base} + mdl_size;
            cand = {1'b0, round_up({1'b0, mdl_base}, {1'b0, a})};
            slot = -1;
            for (int i = TableEntries - 1; i >= 0; i--)
                if (tbl_id[i] == 0)
                    slot = i;
            for (int p = 0; slot >= 0 && p <= TableEntries; p++)
            begin
                if (cand + b > lim)
                    break;
                moved = 1'b0;
                for (int i = 0; i < TableEntries && !moved; i++)
                begin
                    e = tbl_start[i] + tbl_len[i];
                    if (tbl_id[i] != 0 && cand < e && tbl_start[i] < cand + b)
                    begin
                        cand = round_up(e[24:0], {1'b0, a});
                        moved = 1'b1;
                    end
                end
                if (!moved)
                begin
                    if (mdl_next_id == 0)
                        mdl_next_id = 32'd1;
                    g.id = mdl_next_id;
                    mdl_next_id = mdl_next_id + 1;
                    g.addr = cand[23:0];
                    tbl_id[slot] = g.id;
                    tbl_start[slot] = g.addr;
                    tbl_len[slot] = b;
                    live_ids.push_back(g.id);
                    g.st = ST_OK;
                    break;
                end
            end
        end
        return g;
    endfunction

    // Receiver: random stall, long hold-offs on request, and the result check.
    always @(posedge clk)
    begin
        grant_t want;
        if (out_valid && !out_stall)
        begin
            beats_checked <= beats_checked + 1;
            if (pending_grants.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat: status %0d", status);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (status !== want.st || assigned_id !== want.id ||
                    granted_address !== want.addr)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                                 want.st, want.id, want.addr,
                                 status, assigned_id, granted_address);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_write(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Valid stays high after an accepted beat until the next call either idles or
    // presents the next beat, so back-to-back beats need no gap.
    task automatic send_request(logic k, logic [23:0] b, logic [23:0] a, logic [31:0] rid);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        request_bytes <= b;
        alignment <= a;
        release_id <= rid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        g = predict_grant(k, b, a, rid);
        if (k == 1'b0 && g.st == ST_OK)
            grants_ok++;
        pending_grants.push_back(g);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_region(logic [23:0] b, logic [23:0] s);
        drain();
        reg_write(REG_ACTIVE, 32'd0);
        reg_write(REG_BASE, {8'd0, b});
        reg_write(REG_SIZE, {8'd0, s});
        reg_write(REG_ACTIVE, 32'd1);
    endtask

    function automatic logic [23:0] rand_align();
        return 24'd1 << $urandom_range(4, 16);
    endfunction

    task automatic random_traffic(int n);
        int          pick;
        logic [31:0] rid;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_request(1'b0, 24'($urandom_range(1, 1 << $urandom_range(4, 20))),
                             rand_align(), 32'd0);
            else if (pick < 85 && live_ids.size() != 0)
            begin
                int j;
                j = $urandom_range(live_ids.size() - 1);
                rid = live_ids[j];
                live_ids.delete(j);
                send_request(1'b1, 24'd0, 24'd0, rid);
            end
            else if (pick < 92)
                send_request(1'b1, 24'd0, 24'd0, $urandom());
            else
                send_request(1'($urandom()), 24'($urandom()), 24'($urandom()),
                             ($urandom_range(1) != 0) ? $urandom() : 32'd0);
        end
    endtask

    task automatic test_directed();
        send_request(1'b0, 24'd64, 24'd16, 32'd0);
        set_region(24'h100000, 24'h010000);
        send_request(1'b0, 24'd64, 24'd16, 32'd0);
        drain();
        reg_write(REG_ACTIVE, 32'd0);
        reg_write(REG_ACTIVE, 32'd1);
        send_request(1'b0, 24'd64, 24'd16, 32'd0);
        set_region(24'hFF0000, 24'h010000);
        send_request(1'b0, 24'd0, 24'd16, 32'd0);
        send_request(1'b0, 24'd16, 24'd8, 32'd0);
        send_request(1'b0, 24'd16, 24'd131072, 32'd0);
        send_request(1'b0, 24'd16, 24'd48, 32'd0);
        send_request(1'b0, 24'd16, 24'd16, 32'd1);
        send_request(1'b1, 24'd1, 24'd0, 32'd1);
        send_request(1'b1, 24'd0, 24'd16, 32'd1);
        send_request(1'b1, 24'd0, 24'd0, 32'd0);
        send_request(1'b0, 24'hFFFFFF, 24'd65536, 32'd0);
        send_request(1'b0, 24'd65536, 24'd65536, 32'd0);
        send_request(1'b0, 24'd1, 24'd16, 32'd0);
        send_request(1'b1, 24'd0, 24'd0, 32'd1);
        send_request(1'b1, 24'd0, 24'd0, 32'hFFFFFFFF);
        set_region(24'hF00000, 24'h100000);
        for (int i = 0; i < TableEntries + 1; i++)
            send_request(1'b0, 24'd17, 24'd32, 32'd0);
        // Region writes while the session is active must be ignored.
        drain();
        reg_write(REG_BASE, 32'h200000);
        reg_write(REG_SIZE, 32'hFFFFFF);
        send_request(1'b1, 24'd0, 24'd0, 32'd3);
        send_request(1'b0, 24'd100, 24'd16, 32'd0);
    endtask

    task automatic test_id_wrap();
        set_region(24'h100000, 24'h100000);
        for (int i = 0; i < 3; i++)
        begin
            send_request(1'b0, 24'd16, 24'd16, 32'd0);
            send_request(1'b1, 24'd0, 24'd0, live_ids.pop_front());
        end
        drain();
        mdl_next_id = 32'hFFFFFFFE;
        // The block cannot be preset, so the wrap is reached only by model comparison of
        // a full run; here the predictor is restored from a session restart instead.
        reg_write(REG_ACTIVE, 32'd0);
        reg_write(REG_ACTIVE, 32'd1);
    endtask

    task automatic test_unconfigured();
        set_region(24'h0F0000, 24'h010000);
        send_request(1'b0, 24'd16, 24'd16, 32'd0);
        set_region(24'h100800, 24'h010000);
        send_request(1'b0, 24'd16, 24'd16, 32'd0);
        set_region(24'h100000, 24'h000000);
        send_request(1'b1, 24'd0, 24'd0, 32'd5);
        set_region(24'hF00000, 24'h110000);
        send_request(1'b0, 24'd16, 24'd16, 32'd0);
        set_region(24'h100000, 24'h008000);
        send_request(1'b0, 24'd16, 24'd16, 32'd0);
        set_region(24'hFFFFFF, 24'hFFFFFF);
        send_request(1'b0, 24'd16, 24'd16, 32'd0);
    endtask

    task automatic test_random_phases();
        set_region(24'h100000, 24'hF00000);
        send_idle_pct = 37;
        recv_idle_pct = 79;
        random_traffic(350);
        set_region(24'h800000, 24'h040000);
        send_idle_pct = 79;
        recv_idle_pct = 37;
        random_traffic(350);
        set_region(24'h120000, 24'h200000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(350);
    endtask

    task automatic test_backpressure();
        set_region(24'h300000, 24'h080000);
        hold_cycles = 2000;
        random_traffic(40);
        drain();
        random_traffic(40);
    endtask

    initial
    begin
        mdl_base = '0;
        mdl_size = '0;
        mdl_active = 1'b0;
        wipe_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_id_wrap();
        test_unconfigured();
        test_random_phases();
        test_backpressure();
        drain();
        $display("Covered %0d request beats, %0d results checked, %0d successful grants,",
                 beats_sent, beats_checked, grants_ok);
        $display("over operand checks, region validity, table full and long stalls.");
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[aligned_first_fit_region_allocator_unit.f]
src/affra_pkg.sv
src/affra_front.sv
src/affra_back.sv
src/aligned_first_fit_region_allocator_unit.sv
src/affra_checker.sv
test/testbench.sv
